/* design/intel_hex_dump_encoder_assert.svh */
// Assertion macros shared by the intel_hex_dump_encoder RTL files
`ifndef INTEL_HEX_DUMP_ENCODER_ASSERT_SVH
`define INTEL_HEX_DUMP_ENCODER_ASSERT_SVH
`ifndef ASSERT_OFF
// Check a property at every clock edge outside reset
`define IHDE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property at every clock edge, reset included
`define IHDE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IHDE_ASSERT(lbl, clk, rst_n, prop, msg)
`define IHDE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* design/ihde_pkg.sv */
// Types, constants and character helpers for the Intel HEX dump encoder
`default_nettype none
package ihde_pkg;

    localparam int MAX_RECORD_DEF  = 255;
    localparam int MEM_SIZE_DEF    = 512;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int START_W     = 9;
    localparam int LEN_W       = 10;
    localparam int BYTE_W      = 8;
    localparam int ADDR_W      = 16;
    localparam int MEMSZ_W     = 17;
    localparam int IN_TDATA_W  = 32;
    localparam int OFF_W       = 4;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] REC_TYPE_EOF  = 8'h01;
    localparam logic [7:0] EOF_CHECKSUM  = 8'hFF;

    // Character groups of one command, in output order
    typedef enum logic [1:0] {
        SEG_HDR  = 2'd0,
        SEG_DATA = 2'd1,
        SEG_TRL  = 2'd2,
        SEG_EOF  = 2'd3
    } t_seg;

    // One queued request: which groups to send and their payload
    typedef struct packed {
        logic              eof;
        logic              trl;
        logic              dat;
        logic              hdr;
        logic [7:0]        cnt;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
        logic [7:0]        csum;
    } t_cmd;

    // Upper-case hex digit of a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] n8;
        n8 = {4'h0, nib};
        return (nib < 4'd10) ? (8'h30 + n8) : (8'h37 + n8);
    endfunction

    // Offset of the final character in each group
    function automatic logic [OFF_W-1:0] seg_last(input t_seg s);
        logic [OFF_W-1:0] r;
        unique case (s)
            SEG_HDR:  r = 4'd8;
            SEG_DATA: r = 4'd1;
            SEG_TRL:  r = 4'd3;
            SEG_EOF:  r = 4'd12;
            default:  r = 4'd0;
        endcase
        return r;
    endfunction

    // Characters of the end-of-file record ":00000001FF" CR LF
    function automatic logic [7:0] eof_char(input logic [OFF_W-1:0] off);
        logic [7:0] c;
        unique case (off)
            4'd0:    c = CH_COLON;
            4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6: c = CH_ZERO;
            4'd7:    c = hex_char(REC_TYPE_EOF[7:4]);
            4'd8:    c = hex_char(REC_TYPE_EOF[3:0]);
            4'd9:    c = hex_char(EOF_CHECKSUM[7:4]);
            4'd10:   c = hex_char(EOF_CHECKSUM[3:0]);
            4'd11:   c = CH_CR;
            4'd12:   c = CH_LF;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

/* design/ihde_front.sv */
// Front end: accepts dump bytes, tracks records and queues character requests
`default_nettype none
module ihde_front #(
    parameter int MAX_RECORD = ihde_pkg::MAX_RECORD_DEF,
    parameter int MEM_SIZE   = ihde_pkg::MEM_SIZE_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire logic [ihde_pkg::START_W-1:0] i_base_addr,
    input  wire logic [ihde_pkg::LEN_W-1:0]   i_total_len,
    input  wire logic [ihde_pkg::BYTE_W-1:0]  i_data_byte,
    output logic                              o_ready,
    input  wire logic                         i_full,
    output logic                              o_push,
    output ihde_pkg::t_cmd                    o_cmd
);
    import ihde_pkg::*;

    localparam logic [MEMSZ_W-1:0] MEM_SZ  = MEMSZ_W'(MEM_SIZE);
    localparam logic [LEN_W-1:0]   MAX_REC = LEN_W'(MAX_RECORD);

    logic              r_active,  n_active;
    logic [LEN_W-1:0]  r_bytes_left, n_bytes_left;
    logic [LEN_W-1:0]  r_skip_left,  n_skip_left;
    logic [7:0]        r_record_left, n_record_left;
    logic [ADDR_W-1:0] r_record_address, n_record_address;
    logic [7:0]        r_running_sum, n_running_sum;

    logic              accept;
    logic [MEMSZ_W-1:0] start_ext, len_ext, avail, keep_ext;
    logic [LEN_W-1:0]  keep, items;
    logic              eof_only, produce;
    logic [LEN_W-1:0]  e_bl, e_skip, cnt_wide;
    logic [7:0]        e_rl, e_rs, cnt, sum0, sum1, rl_base, rl1;
    logic [ADDR_W-1:0] e_ra;
    t_cmd              cmd;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept && produce;
    assign o_cmd   = cmd;

    // Clip the dump length at the end of memory
    always_comb begin
        start_ext = {{(MEMSZ_W-START_W){1'b0}}, i_base_addr};
        len_ext   = {{(MEMSZ_W-LEN_W){1'b0}}, i_total_len};
        avail     = (start_ext < MEM_SZ) ? (MEM_SZ - start_ext) : '0;
        keep_ext  = (len_ext < avail) ? len_ext : avail;
        keep      = keep_ext[LEN_W-1:0];
        items     = (i_total_len == '0) ? LEN_W'(1) : i_total_len;
    end

    // Work out the next record state and the request for this byte
    always_comb begin
        e_bl     = r_bytes_left;
        e_skip   = r_skip_left;
        e_rl     = r_record_left;
        e_ra     = r_record_address;
        e_rs     = r_running_sum;
        eof_only = 1'b0;
        if (!r_active) begin
            e_ra = {{(ADDR_W-START_W){1'b0}}, i_base_addr};
            e_rl = '0;
            e_rs = '0;
            if (keep == '0) begin
                eof_only = 1'b1;
            end else begin
                e_bl   = keep;
                e_skip = items - keep;
            end
        end

        cnt_wide = (e_bl < MAX_REC) ? e_bl : MAX_REC;
        cnt      = cnt_wide[7:0];
        sum0     = (e_rl == '0) ? (cnt + e_ra[15:8] + e_ra[7:0]) : e_rs;
        sum1     = sum0 + i_data_byte;
        rl_base  = (e_rl == '0) ? cnt : e_rl;
        rl1      = rl_base - 8'd1;

        n_active         = r_active;
        n_bytes_left     = e_bl;
        n_skip_left      = e_skip;
        n_record_left    = e_rl;
        n_record_address = e_ra;
        n_running_sum    = e_rs;
        produce          = 1'b0;
        cmd              = '0;
        cmd.cnt          = cnt;
        cmd.addr         = e_ra;
        cmd.data         = i_data_byte;
        cmd.csum         = 8'h00 - sum1;

        priority if (eof_only) begin
            cmd.eof      = 1'b1;
            produce      = 1'b1;
            n_skip_left  = items - LEN_W'(1);
            n_bytes_left = '0;
            n_active     = (n_skip_left != '0);
        end else if (e_bl == '0) begin
            // Swallow a clipped item
            n_skip_left = (e_skip != '0) ? (e_skip - LEN_W'(1)) : '0;
            n_active    = (n_skip_left != '0);
        end else begin
            produce          = 1'b1;
            cmd.hdr          = (e_rl == '0);
            cmd.dat          = 1'b1;
            cmd.trl          = (rl1 == '0);
            cmd.eof          = (e_bl == LEN_W'(1));
            n_record_left    = rl1;
            n_bytes_left     = e_bl - LEN_W'(1);
            n_record_address = e_ra + ADDR_W'(1);
            n_running_sum    = (rl1 == '0) ? 8'h00 : sum1;
            n_active         = !((e_bl == LEN_W'(1)) && (e_skip == '0));
        end
    end

    // Hold record state, advance on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active         <= 1'b0;
            r_bytes_left     <= '0;
            r_skip_left      <= '0;
            r_record_left    <= '0;
            r_record_address <= '0;
            r_running_sum    <= '0;
        end else if (accept) begin
            r_active         <= n_active;
            r_bytes_left     <= n_bytes_left;
            r_skip_left      <= n_skip_left;
            r_record_left    <= n_record_left;
            r_record_address <= n_record_address;
            r_running_sum    <= n_running_sum;
        end
    end

endmodule
`default_nettype wire

/* design/ihde_queue.sv */
// Short request queue between the front end and the character sequencer
`default_nettype none
`include "intel_hex_dump_encoder_assert.svh"
module ihde_queue #(
    parameter int DEPTH = ihde_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  ihde_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  wire logic      i_pop,
    output ihde_pkg::t_cmd o_cmd,
    output logic           o_empty
);
    import ihde_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Store requests
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : (r_wr_ptr + PTR_W'(1));
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : (r_rd_ptr + PTR_W'(1));
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    `IHDE_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_FULL, "queue overfilled")
    `IHDE_ASSERT(a_no_push_full, i_clk, i_rst_n, !(i_push && o_full), "push into full queue")
    `IHDE_ASSERT(a_no_pop_empty, i_clk, i_rst_n, !(i_pop && o_empty), "pop from empty queue")

endmodule
`default_nettype wire

/* design/ihde_back.sv */
// Back end: expands queued requests into HEX characters, one per cycle while i_tready allows
`default_nettype none
`include "intel_hex_dump_encoder_assert.svh"
module ihde_back (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_empty,
    input  ihde_pkg::t_cmd  i_cmd,
    output logic            o_pop,
    output logic            o_tvalid,
    input  wire logic       i_tready,
    output logic [7:0]      o_tdata,
    output logic            o_tlast
);
    import ihde_pkg::*;

    logic             r_busy;
    t_cmd             r_cmd;
    t_seg             r_seg;
    logic [OFF_W-1:0] r_off;
    logic             r_tvalid;
    logic [7:0]       r_tdata;
    logic             r_tlast;

    logic [3:0]       en, in_en;
    logic             adv, seg_end, has_next, last_char, load;
    t_seg             next_seg, first_seg;
    logic [7:0]       ch;

    assign en    = {r_cmd.eof, r_cmd.trl, r_cmd.dat, r_cmd.hdr};
    assign in_en = {i_cmd.eof, i_cmd.trl, i_cmd.dat, i_cmd.hdr};

    // Pick the character at the current group and offset
    always_comb begin
        unique case (r_seg)
            SEG_HDR: begin
                unique case (r_off)
                    4'd0:    ch = CH_COLON;
                    4'd1:    ch = hex_char(r_cmd.cnt[7:4]);
                    4'd2:    ch = hex_char(r_cmd.cnt[3:0]);
                    4'd3:    ch = hex_char(r_cmd.addr[15:12]);
                    4'd4:    ch = hex_char(r_cmd.addr[11:8]);
                    4'd5:    ch = hex_char(r_cmd.addr[7:4]);
                    4'd6:    ch = hex_char(r_cmd.addr[3:0]);
                    default: ch = CH_ZERO;
                endcase
            end
            SEG_DATA: ch = (r_off == '0) ? hex_char(r_cmd.data[7:4])
                                         : hex_char(r_cmd.data[3:0]);
            SEG_TRL: begin
                unique case (r_off)
                    4'd0:    ch = hex_char(r_cmd.csum[7:4]);
                    4'd1:    ch = hex_char(r_cmd.csum[3:0]);
                    4'd2:    ch = CH_CR;
                    default: ch = CH_LF;
                endcase
            end
            SEG_EOF:  ch = eof_char(r_off);
            default:  ch = 8'h00;
        endcase
    end

    // Find the following group of this request and the first group of the next
    always_comb begin
        has_next  = 1'b0;
        next_seg  = SEG_HDR;
        first_seg = SEG_EOF;
        for (int k = 3; k >= 0; k--) begin
            if (en[k] && (2'(k) > r_seg)) begin
                has_next = 1'b1;
                next_seg = t_seg'(2'(k));
            end
            if (in_en[k]) begin
                first_seg = t_seg'(2'(k));
            end
        end
    end

    assign seg_end   = (r_off == seg_last(r_seg));
    assign last_char = seg_end && !has_next;
    assign adv       = r_busy && (!r_tvalid || i_tready);
    assign load      = (!r_busy || (adv && last_char)) && !i_empty;
    assign o_pop     = load;

    assign o_tvalid = r_tvalid;
    assign o_tdata  = r_tdata;
    assign o_tlast  = r_tlast;

    // Hold the current request, step through its characters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_seg    <= SEG_HDR;
            r_off    <= '0;
            r_tvalid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
                r_seg  <= first_seg;
                r_off  <= '0;
            end else if (adv) begin
                if (last_char) begin
                    r_busy <= 1'b0;
                end else if (seg_end) begin
                    r_seg <= next_seg;
                    r_off <= '0;
                end else begin
                    r_off <= r_off + OFF_W'(1);
                end
            end

            if (adv) begin
                r_tvalid <= 1'b1;
            end else if (i_tready) begin
                r_tvalid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd <= i_cmd;
        end
        if (adv) begin
            r_tdata <= ch;
            r_tlast <= last_char;
        end
    end

    `IHDE_ASSERT(a_seg_enabled, i_clk, i_rst_n, r_busy |-> en[r_seg], "active group not requested")
    `IHDE_ASSERT(a_off_bound, i_clk, i_rst_n, r_busy |-> (r_off <= seg_last(r_seg)), "offset past group")
    `IHDE_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_tvalid, "output valid after reset")

endmodule
`default_nettype wire

/* design/intel_hex_dump_encoder.sv */
// Intel HEX dump encoder: an accepted byte is queued and loaded into the back end before
// its first character is registered; output runs at one character per cycle unless stalled.
// Each kept byte yields 2 to 28 characters, so the character sequencer sets the pace;
// bytes are accepted one per cycle while the request queue has room.
// Reset (i_rst_n low, synchronous) ends any dump, empties the queue, drops m_axis_tvalid.
`default_nettype none
module intel_hex_dump_encoder #(
    parameter int MAX_RECORD  = ihde_pkg::MAX_RECORD_DEF,
    parameter int MEM_SIZE    = ihde_pkg::MEM_SIZE_DEF,
    parameter int QUEUE_DEPTH = ihde_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [8:0] base_addr, [18:9] total_len, [26:19] data_byte, [31:27] zero
    input  wire logic [ihde_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [7:0] ascii_char
    output logic [7:0]                           m_axis_tdata,
    output logic                                 m_axis_tlast
);
    import ihde_pkg::*;

    logic push, full, pop, empty;
    t_cmd front_cmd, queue_cmd;

    ihde_front #(
        .MAX_RECORD (MAX_RECORD),
        .MEM_SIZE   (MEM_SIZE)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .i_base_addr  (s_axis_tdata[8:0]),
        .i_total_len  (s_axis_tdata[18:9]),
        .i_data_byte  (s_axis_tdata[26:19]),
        .o_ready      (s_axis_tready),
        .i_full       (full),
        .o_push       (push),
        .o_cmd        (front_cmd)
    );

    ihde_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (queue_cmd),
        .o_empty (empty)
    );

    ihde_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_cmd    (queue_cmd),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast)
    );

endmodule
`default_nettype wire
